[sv/encp_pkg.sv]
// Shared types and constants for the encoder edge-period speed block.
// Used by encp_div, encoder_edge_period_speed and the testbench; depends on nothing else.

package encp_pkg;

  // Timer stamp bits actually used; the interval is taken modulo 2^StampBits
  localparam int unsigned StampBits = 64;
  // Wide enough to compare the interval with a 32-bit gap or saturation limit
  localparam int unsigned CmpW      = (StampBits > 32) ? StampBits : 32;

  // Field and register widths
  localparam int unsigned GainW     = 48;
  localparam int unsigned GapW      = 32;
  localparam int unsigned SpeedW    = 32;
  localparam int unsigned IntvW     = 32;
  localparam int unsigned DirW      = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned InDataW   = 72;   // 64 + 1 + 2 packed, padded to bytes
  localparam int unsigned OutDataW  = 64;

  // Divider step counter
  localparam int unsigned DivCntW   = $clog2(GainW);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MIN_GAP   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_LOW  = 2'd2;

  // Register reset values
  localparam logic [GapW-1:0]  GAP_RESET       = 32'd25000;
  localparam logic [GainW-1:0] GAIN_HIGH_RESET = 48'd63727121000;
  localparam logic [GainW-1:0] GAIN_LOW_RESET  = 48'd39216611328;

  // Direction codes; both remaining codes mean reverse
  localparam logic [DirW-1:0] DIR_STOP = 2'b00;
  localparam logic [DirW-1:0] DIR_FWD  = 2'b01;

  // Saturation limits
  localparam logic [GainW-1:0]  POS_LIMIT = 48'h0000_7FFF_FFFF;
  localparam logic [GainW-1:0]  NEG_LIMIT = 48'h0000_8000_0000;
  localparam logic [CmpW-1:0]   INTV_MAX  = CmpW'(32'hFFFF_FFFF);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_HOLD
  } state_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/encoder_edge_period_speed.sv]
// Encoder edge-period speed: one edge beat in, zero or one speed beat out.
// An edge that yields a result starts the 48-step divider; the quotient then goes through the output
// register. No edge is taken while a division runs or its result waits for the output; edges
// without a result are taken one per cycle while the block is idle.
// Reset (rst_ni low, asynchronous): registers to defaults, stamp and level to 0.
// Depends on encp_pkg and encp_div.

module encoder_edge_period_speed import encp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Edge beats
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // stamp_ticks[63:0], sensor_level[64],
                                                // direction[66:65], zero pad
  // Speed beats
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // speed[31:0], interval_ticks[63:32]
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  state_e               state_q, state_d;

  logic [GapW-1:0]      min_gap_q;
  logic [GainW-1:0]     gain_hi_q;
  logic [GainW-1:0]     gain_lo_q;

  logic [StampBits-1:0] last_stamp_q;
  logic                 last_level_q;

  logic [StampBits-1:0] interval_q;
  logic [DirW-1:0]      dir_q;

  logic                 out_valid_q, out_valid_d;
  logic [SpeedW-1:0]    out_speed_q;
  logic [IntvW-1:0]     out_intv_q;

  logic                 in_acc;
  logic [StampBits-1:0] in_stamp;
  logic                 in_level;
  logic [DirW-1:0]      in_dir;
  logic [StampBits-1:0] in_interval;
  logic                 fire;
  logic                 div_start;
  logic                 load_out;
  logic                 out_free;

  div_stat_t            div_stat;
  logic [GainW-1:0]     quotient;
  logic [SpeedW-1:0]    speed_val;
  logic [CmpW-1:0]      intv_ext;
  logic [IntvW-1:0]     intv_val;

  // Unpack the edge beat
  assign in_stamp    = s_axis_tdata_i[StampBits-1:0];
  assign in_level    = s_axis_tdata_i[64];
  assign in_dir      = s_axis_tdata_i[66:65];
  assign in_interval = in_stamp - last_stamp_q;
  assign fire        = (CmpW'(in_interval) > CmpW'(min_gap_q)) && (in_level != last_level_q);
  assign in_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free    = !out_valid_q || m_axis_tready_i;

  // Sequencer
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && fire) begin
          div_start = 1'b1;
          state_d   = ST_CALC;
        end
      end
      ST_CALC: begin
        if (div_stat.done) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d  = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= GAP_RESET;
      gain_hi_q <= GAIN_HIGH_RESET;
      gain_lo_q <= GAIN_LOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_GAP:   min_gap_q <= cfg_data_i[GapW-1:0];
        CFG_GAIN_HIGH: gain_hi_q <= cfg_data_i[GainW-1:0];
        CFG_GAIN_LOW:  gain_lo_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Last edge, updated on every beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
      last_level_q <= 1'b0;
    end else if (in_acc) begin
      last_stamp_q <= in_stamp;
      last_level_q <= in_level;
    end
  end

  // Operands kept for the result
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      interval_q <= in_interval;
      dir_q      <= in_dir;
    end
  end

  encp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_level ? gain_hi_q : gain_lo_q),
    .divisor_i  (in_interval),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Saturate and sign the quotient; a zero gain gives zero anyway
  always_comb begin
    logic [GainW-1:0] q_lim;
    q_lim     = '0;
    speed_val = '0;
    if (dir_q == DIR_STOP) begin
      speed_val = '0;
    end else if (dir_q == DIR_FWD) begin
      q_lim     = (quotient > POS_LIMIT) ? POS_LIMIT : quotient;
      speed_val = q_lim[SpeedW-1:0];
    end else begin
      q_lim     = (quotient > NEG_LIMIT) ? NEG_LIMIT : quotient;
      speed_val = SpeedW'(0) - q_lim[SpeedW-1:0];
    end
  end

  assign intv_ext = CmpW'(interval_q);
  assign intv_val = (intv_ext > INTV_MAX) ? '1 : intv_ext[IntvW-1:0];

  // Output register
  assign out_valid_d = load_out ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_speed_q <= speed_val;
      out_intv_q  <= intv_val;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_intv_q, out_speed_q};

`ifndef SYNTHESIS
  // Divider finishes only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_CALC)
    else $error("divider done outside calc state");

  // A firing edge starts a division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fire) |=> (state_q == ST_CALC && div_stat.busy))
    else $error("firing edge did not start divider");

  // An edge that does not fire leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !fire) |=> state_q == ST_IDLE)
    else $error("non-firing edge left block busy");

  // Waiting for the output only when a beat is pending there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> out_valid_q)
    else $error("hold state without pending output beat");
`endif

endmodule

[sv/encp_div.sv]
// Restoring divider, one quotient bit per cycle, GainW steps per division.
// Depends on encp_pkg for widths and the status struct.

module encp_div import encp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [GainW-1:0]     dividend_i,
  input  logic [StampBits-1:0] divisor_i,
  output div_stat_t            stat_o,
  output logic [GainW-1:0]     quotient_o
);

  logic [StampBits-1:0] rem_q, rem_d;
  logic [GainW-1:0]     quo_q, quo_d;
  logic [StampBits-1:0] dvs_q;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [StampBits:0]   shifted;
  logic [StampBits:0]   diff;
  logic                 ge;

  // One shift-compare-subtract step
  assign shifted = {rem_q, quo_q[GainW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = ~diff[StampBits];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[StampBits-1:0] : shifted[StampBits-1:0];
      quo_d = {quo_q[GainW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(GainW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

[tb/tb.sv]
// Testbench for encoder_edge_period_speed: a directed table of edge beats, then random
// edge streams under several register settings, checked against a speed predictor.
// Depends on encp_pkg and the RTL of the block.

module tb;
  import encp_pkg::*;

  // Index past the register list; writes to it must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam int RESULT_LATENCY  = 50;
  localparam int STALL_LIMIT     = 4000;
  localparam int EDGES_PER_PHASE = 177;

  typedef struct packed {
    logic              fire;
    logic [SpeedW-1:0] speed;
    logic [IntvW-1:0]  intv;
  } speed_res_t;

  typedef struct packed {
    logic [63:0]     stamp;
    logic            level;
    logic [DirW-1:0] dir;
    logic            typed;   // res holds a hand-computed result
    speed_res_t      res;
  } edge_row_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;   // stamp_ticks[63:0], sensor_level[64], direction[66:65]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;         // speed[31:0], interval_ticks[63:32]
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Predictor copy of registers and edge state
  logic [GapW-1:0]  gap_ticks  = GAP_RESET;
  logic [GainW-1:0] gain_hi    = GAIN_HIGH_RESET;
  logic [GainW-1:0] gain_lo    = GAIN_LOW_RESET;
  logic [63:0]      last_stamp = '0;
  logic             last_level = 1'b0;

  speed_res_t speed_q[$];
  int errors     = 0;
  int n_edges    = 0;
  int n_results  = 0;
  int burst_left = 0;
  int ready_hold = 0;
  int quiet      = 0;

  // Directed edges, reset register values throughout
  edge_row_t directed [16] = '{
    // glitch, then interval equal to the gap, then level unchanged
    '{64'd100,     1'b1, DIR_FWD,  1'b1, '{1'b0, 32'd0, 32'd0}},
    '{64'd25100,   1'b0, DIR_FWD,  1'b1, '{1'b0, 32'd0, 32'd0}},
    '{64'd50101,   1'b0, DIR_FWD,  1'b1, '{1'b0, 32'd0, 32'd0}},
    // 1e6 tick periods: forward, reverse, stopped, reverse as pattern -2
    '{64'd1050101, 1'b1, DIR_FWD,  1'b1, '{1'b1, 32'd63727, 32'd1000000}},
    '{64'd2050101, 1'b0, 2'b11,    1'b1, '{1'b1, -32'sd39216, 32'd1000000}},
    '{64'd3050101, 1'b1, DIR_STOP, 1'b1, '{1'b1, 32'd0, 32'd1000000}},
    '{64'd4050101, 1'b0, 2'b10,    1'b1, '{1'b1, -32'sd39216, 32'd1000000}},
    // timer wrap with huge intervals, interval saturates
    '{64'd0,                  1'b1, DIR_FWD, 1'b1, '{1'b1, 32'd0, 32'hFFFF_FFFF}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, DIR_FWD, 1'b1, '{1'b1, 32'd0, 32'hFFFF_FFFF}},
    '{64'h0000_0000_0001_0000, 1'b1, DIR_FWD, 1'b0, '{1'b0, 32'd0, 32'd0}},
    // interval of exactly 2^32-1, then 2^32
    '{64'h0000_0001_0000_FFFF, 1'b0, DIR_FWD, 1'b1, '{1'b1, 32'd9, 32'hFFFF_FFFF}},
    '{64'h0000_0002_0000_FFFF, 1'b1, 2'b11,   1'b1, '{1'b1, -32'sd14, 32'hFFFF_FFFF}},
    '{64'h0000_0002_0001_86A0, 1'b0, 2'b11,    1'b0, '{1'b0, 32'd0, 32'd0}},
    '{64'h0000_0002_0001_F000, 1'b1, DIR_STOP, 1'b0, '{1'b0, 32'd0, 32'd0}},
    '{64'h8000_0000_0000_0000, 1'b0, DIR_FWD,  1'b0, '{1'b0, 32'd0, 32'd0}},
    '{64'h8000_0000_0000_61A9, 1'b1, DIR_FWD,  1'b0, '{1'b0, 32'd0, 32'd0}}
  };

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  encoder_edge_period_speed dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // Speed predictor: updates the edge state, returns the result if one fires
  function automatic speed_res_t edge_speed(input logic [63:0] stamp, input logic level,
                                            input logic [DirW-1:0] dir);
    logic [63:0]      intv;
    logic [63:0]      quot;
    logic [GainW-1:0] gain;
    speed_res_t       r;
    intv   = stamp - last_stamp;
    r.fire = (intv > {32'd0, gap_ticks}) && (level != last_level);
    last_stamp = stamp;
    last_level = level;
    gain = level ? gain_hi : gain_lo;
    quot = (intv != 64'd0) ? {16'd0, gain} / intv : 64'd0;
    if (dir == DIR_STOP) begin
      r.speed = '0;
    end else if (dir == DIR_FWD) begin
      r.speed = (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
    end else begin
      r.speed = (quot > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - quot[31:0];
    end
    r.intv = (intv > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : intv[31:0];
    return r;
  endfunction

  // One edge beat; the sender may idle between bursts of random length
  task automatic send_edge(input logic [63:0] stamp, input logic level,
                           input logic [DirW-1:0] dir, input logic typed,
                           input speed_res_t typed_res);
    int         gap;
    speed_res_t r;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, dir, level, stamp};
    do @(posedge clk_i); while (!s_tready);
    r = edge_speed(stamp, level, dir);
    if (typed) r = typed_res;
    if (r.fire) speed_q.push_back(r);
    n_edges++;
  endtask

  // Register write, mirrored into the predictor after its edge
  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MIN_GAP:   gap_ticks = data[GapW-1:0];
      CFG_GAIN_HIGH: gain_hi   = data;
      CFG_GAIN_LOW:  gain_lo   = data;
      default: ;
    endcase
  endtask

  // Let every pending speed beat come out, then let the divider settle
  task automatic drain_speeds();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (speed_q.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic configure(input logic [GapW-1:0] gap, input logic [GainW-1:0] hi,
                           input logic [GainW-1:0] lo);
    drain_speeds();
    reg_write(CFG_SPARE, 48'({$urandom, $urandom}));
    // upper data bits are junk for the 32-bit gap register
    reg_write(CFG_MIN_GAP, {16'hA5C3, gap});
    reg_write(CFG_GAIN_HIGH, hi);
    reg_write(CFG_GAIN_LOW, lo);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed periods with level toggles, some glitches and wraps
  task automatic random_edges(input int count);
    logic [63:0] incr;
    logic        lvl;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1:    incr = 64'($urandom_range(0, 3));
        2:       incr = {32'd0, gap_ticks} + 64'($urandom_range(0, 2)) - 64'd1;
        3:       incr = {$urandom, $urandom};
        default: incr = {32'd0, gap_ticks} + 64'd1 + 64'($urandom_range(0, 200000));
      endcase
      lvl = ($urandom_range(0, 9) < 8) ? ~last_level : last_level;
      send_edge(last_stamp + incr, lvl, 2'($urandom_range(0, 3)), 1'b0, '0);
    end
  endtask

  // Receiver: stalls, short ready runs and long stretches with no stall
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          m_tready  <= 1'b0;
          ready_hold = $urandom_range(1, 20);
        end
        1, 2: begin
          m_tready  <= 1'b1;
          ready_hold = $urandom_range(1, 30);
        end
        default: begin
          m_tready  <= 1'b1;
          ready_hold = $urandom_range(100, 300);
        end
      endcase
    end
  end

  // Compare each speed beat with the oldest expectation
  always @(posedge clk_i) begin
    speed_res_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (speed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected speed beat: expected none, actual speed %0d interval %0d",
                 $time, $signed(m_tdata[31:0]), m_tdata[63:32]);
      end else begin
        want = speed_q.pop_front();
        n_results++;
        if (m_tdata[31:0] !== want.speed) begin
          errors++;
          $display("%0t: speed mismatch: expected %0d, actual %0d",
                   $time, $signed(want.speed), $signed(m_tdata[31:0]));
        end
        if (m_tdata[63:32] !== want.intv) begin
          errors++;
          $display("%0t: interval mismatch: expected %0d, actual %0d",
                   $time, want.intv, m_tdata[63:32]);
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d speed beats pending",
               $time, quiet, speed_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_edge(directed[i].stamp, directed[i].level, directed[i].dir,
                directed[i].typed, directed[i].res);
    end

    // saturation: no gap, full-scale gains
    configure(32'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    random_edges(EDGES_PER_PHASE);
    // widest gap: only intervals above 2^32-1 count
    configure(32'hFFFF_FFFF, 48'd0, 48'hFFFF_FFFF_FFFF);
    random_edges(EDGES_PER_PHASE);
    configure($urandom_range(0, 100000), 48'({$urandom, $urandom}),
              48'({$urandom, $urandom}));
    random_edges(EDGES_PER_PHASE);
    configure($urandom_range(0, 50), 48'({$urandom, $urandom}),
              48'({$urandom, $urandom}));
    random_edges(EDGES_PER_PHASE);
    configure(GAP_RESET, GAIN_HIGH_RESET, GAIN_LOW_RESET);
    random_edges(EDGES_PER_PHASE);
    drain_speeds();

    $display("Sent %0d edge beats over six register settings; checked %0d speed beats.",
             n_edges, n_results);
    $display("Covered glitches, unchanged levels, wraps, saturation and all directions.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
